@@ rtl/nfcrp_pkg.sv @@
package nfcrp_pkg;

  // Fixed bytes of a normal information frame sent toward the host.
  localparam logic [7:0] FramePreamble  = 8'h00;
  localparam logic [7:0] FrameStart1    = 8'h00;
  localparam logic [7:0] FrameStart2    = 8'hFF;
  localparam logic [7:0] FrameDirToHost = 8'hD5;

  // Configuration register indexes.
  localparam logic CfgSentCommand = 1'b0;
  localparam logic CfgBufCapacity = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START1 = 4'd1,
    PH_START2 = 4'd2,
    PH_LEN    = 4'd3,
    PH_LCS    = 4'd4,
    PH_TFI    = 4'd5,
    PH_CODE   = 4'd6,
    PH_DATA   = 4'd7,
    PH_DCS    = 4'd8,
    PH_POST   = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSPACE = 2'd2
  } status_e;

  // Parser context carried from one byte to the next.
  typedef struct packed {
    phase_e     phase;
    logic [7:0] bytes_left;
    logic [7:0] frame_length;
    logic [7:0] running_sum;
    logic       overflow;
  } ctx_t;

  // One result item.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_done;
    status_e    frame_status;
    logic [7:0] payload_count;
  } res_t;

endpackage

@@ rtl/nfc_response_frame_parser.sv @@
// Response frame parser for a near-field controller link.
// Received bytes enter on the s_axis channel, one byte per transaction; tuser
// marks the first byte (the preamble) of a frame and restarts the parser.
// Results leave on the m_axis channel: either a payload byte (tuser high)
// or the frame end (tlast high) with a status of ok, invalid or no space and
// the payload count. A byte that neither ends a frame nor carries payload
// produces no output transaction.
// Each accepted byte is held in an input register, parsed by one level of
// logic, and its result is written to an output register. With
// m_axis_tready held high one byte is accepted every cycle; the rate is set
// by the single parse stage. When the receiver stalls, the output register
// holds its result and the input register holds at most one more byte,
// after which s_axis_tready drops until the output is taken.
// The configuration port writes the sent command code (index 0) and the
// buffer capacity (index 1); write it only while no frame is in flight, as
// the block itself does not enforce this. Reset clears the parser to idle,
// the command code to 0, the capacity to 255, and empties both registers.
module nfc_response_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Receive byte channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic        s_axis_tuser,  // [0] frame_start
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] payload_byte, [9:8] frame_status,
                                     // [17:10] payload_count, [23:18] zero
  output logic        m_axis_tuser,  // [0] payload_valid
  output logic        m_axis_tlast,  // frame_done
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import nfcrp_pkg::*;

  logic       cmd_we;
  logic [7:0] sent_cmd_q;
  logic [7:0] buf_cap_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  ctx_t       ctx_q;
  ctx_t       ctx_d;

  logic       out_valid_q;
  res_t       out_q;
  logic       res_valid;
  res_t       res;

  logic       advance;
  logic       accept;

  // The input byte moves through the parser when the output register is
  // free or is being emptied in this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  assign cmd_we = cfg_we_i && (cfg_index_i == CfgSentCommand);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_cmd_q <= 8'd0;
      buf_cap_q  <= 8'd255;
    end else begin
      if (cmd_we) begin
        sent_cmd_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == CfgBufCapacity)) begin
        buf_cap_q <= cfg_data_i;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  nfcrp_parse u_parse (
    .cur_i          (ctx_q),
    .rx_byte_i      (in_byte_q),
    .frame_start_i  (in_start_q),
    .sent_command_i (sent_cmd_q),
    .buf_capacity_i (buf_cap_q),
    .nxt_o          (ctx_d),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // Parser context advances once per byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= '{phase: PH_IDLE, bytes_left: 8'd0, frame_length: 8'd0,
                 running_sum: 8'd0, overflow: 1'b0};
    end else if (advance) begin
      ctx_q <= ctx_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.payload_count, out_q.frame_status, out_q.payload_byte};
  assign m_axis_tuser  = out_q.payload_valid;
  assign m_axis_tlast  = out_q.frame_done;

endmodule

@@ rtl/nfcrp_parse.sv @@
module nfcrp_parse (
  input  nfcrp_pkg::ctx_t cur_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            frame_start_i,
  input  logic [7:0]      sent_command_i,
  input  logic [7:0]      buf_capacity_i,
  output nfcrp_pkg::ctx_t nxt_o,
  output logic            res_valid_o,
  output nfcrp_pkg::res_t res_o
);
  import nfcrp_pkg::*;

  logic [7:0] code;
  logic [7:0] left_dec;
  logic       lcs_ok;
  logic       dcs_ok;

  assign code     = 8'(sent_command_i + 8'd1);
  assign left_dec = 8'(cur_i.bytes_left - 8'd1);
  assign lcs_ok   = (8'(cur_i.frame_length + rx_byte_i) == 8'd0);
  assign dcs_ok   = cur_i.overflow || (8'(cur_i.running_sum + rx_byte_i) == 8'd0);

  // Next context.
  always_comb begin
    nxt_o = cur_i;
    if (frame_start_i) begin
      nxt_o.bytes_left   = '0;
      nxt_o.frame_length = '0;
      nxt_o.running_sum  = '0;
      nxt_o.overflow     = 1'b0;
      nxt_o.phase        = (rx_byte_i == FramePreamble) ? PH_START1 : PH_IDLE;
    end else begin
      unique case (cur_i.phase)
        PH_IDLE: begin
          nxt_o.phase = PH_IDLE;
        end
        PH_START1: begin
          nxt_o.phase = (rx_byte_i == FrameStart1) ? PH_START2 : PH_IDLE;
        end
        PH_START2: begin
          nxt_o.phase = (rx_byte_i == FrameStart2) ? PH_LEN : PH_IDLE;
        end
        PH_LEN: begin
          nxt_o.frame_length = rx_byte_i;
          nxt_o.phase        = PH_LCS;
        end
        PH_LCS: begin
          if (lcs_ok) begin
            nxt_o.frame_length = 8'(cur_i.frame_length - 8'd2);
            nxt_o.phase        = PH_TFI;
          end else begin
            nxt_o.phase = PH_IDLE;
          end
        end
        PH_TFI: begin
          nxt_o.phase = (rx_byte_i == FrameDirToHost) ? PH_CODE : PH_IDLE;
        end
        PH_CODE: begin
          if (rx_byte_i == code) begin
            nxt_o.overflow    = cur_i.frame_length > buf_capacity_i;
            nxt_o.running_sum = 8'(FrameDirToHost + code);
            nxt_o.bytes_left  = cur_i.frame_length;
            nxt_o.phase       = (cur_i.frame_length == 8'd0) ? PH_DCS : PH_DATA;
          end else begin
            nxt_o.phase = PH_IDLE;
          end
        end
        PH_DATA: begin
          nxt_o.bytes_left = left_dec;
          if (left_dec == 8'd0) begin
            nxt_o.phase = PH_DCS;
          end
          if (!cur_i.overflow) begin
            nxt_o.running_sum = 8'(cur_i.running_sum + rx_byte_i);
          end
        end
        PH_DCS: begin
          nxt_o.phase = dcs_ok ? PH_POST : PH_IDLE;
        end
        PH_POST: begin
          nxt_o.phase = PH_IDLE;
        end
        default: begin
          nxt_o.phase = PH_IDLE;
        end
      endcase
    end
  end

  // Result for this byte, if any.
  always_comb begin
    res_valid_o         = 1'b0;
    res_o.payload_valid = 1'b0;
    res_o.payload_byte  = '0;
    res_o.frame_done    = 1'b0;
    res_o.frame_status  = ST_OK;
    res_o.payload_count = '0;
    if (frame_start_i) begin
      if (rx_byte_i != FramePreamble) begin
        res_valid_o        = 1'b1;
        res_o.frame_done   = 1'b1;
        res_o.frame_status = ST_INVALID;
      end
    end else begin
      unique case (cur_i.phase) inside
        PH_START1, PH_START2, PH_LCS, PH_TFI, PH_CODE, PH_DCS: begin
          if ((cur_i.phase == PH_START1 && rx_byte_i != FrameStart1) ||
              (cur_i.phase == PH_START2 && rx_byte_i != FrameStart2) ||
              (cur_i.phase == PH_LCS    && !lcs_ok) ||
              (cur_i.phase == PH_TFI    && rx_byte_i != FrameDirToHost) ||
              (cur_i.phase == PH_CODE   && rx_byte_i != code) ||
              (cur_i.phase == PH_DCS    && !dcs_ok)) begin
            res_valid_o        = 1'b1;
            res_o.frame_done   = 1'b1;
            res_o.frame_status = ST_INVALID;
          end
        end
        PH_DATA: begin
          if (!cur_i.overflow) begin
            res_valid_o         = 1'b1;
            res_o.payload_valid = 1'b1;
            res_o.payload_byte  = rx_byte_i;
          end
        end
        PH_POST: begin
          res_valid_o         = 1'b1;
          res_o.frame_done    = 1'b1;
          res_o.frame_status  = cur_i.overflow ? ST_NOSPACE : ST_OK;
          res_o.payload_count = cur_i.frame_length;
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

endmodule

@@ rtl/nfcrp_checker.sv @@
module nfcrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);
  import nfcrp_pkg::*;

  // A stalled result holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Every result is either a payload byte or a frame end, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot({m_axis_tlast, m_axis_tuser}))
    else $error("result kind is not one-hot");

  // Payload results carry no status and no count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[23:8] == 16'd0)
    else $error("payload result carries status or count");

  // An invalid frame reports a zero count, and status code 3 never appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      (m_axis_tdata[9:8] != 2'd3) &&
      ((m_axis_tdata[9:8] != ST_INVALID) || (m_axis_tdata[17:10] == 8'd0)))
    else $error("bad frame end status or count");

  // A new result must trace back to an accepted byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without an accepted byte");

endmodule

bind nfc_response_frame_parser nfcrp_checker u_checker (.*);

@@ test/nfc_response_frame_parser_test.sv @@
`timescale 1ns / 1ps

module nfc_response_frame_parser_test;
  import nfcrp_pkg::*;

  localparam int unsigned CycleLimit    = 600000;
  localparam int unsigned PhaseItems    = 300;
  localparam int unsigned NumPhases     = 5;
  localparam int unsigned MaxPrintedErr = 40;

  // Ways in which a generated frame departs from a well-formed one.
  typedef enum int {
    DEF_NONE,
    DEF_PREAMBLE,
    DEF_START1,
    DEF_START2,
    DEF_LCS,
    DEF_TFI,
    DEF_CODE,
    DEF_DCS,
    DEF_CUT
  } frame_defect_e;

  // One received byte together with its frame start marker.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } rx_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
  logic        s_axis_tuser  = 1'b0;   // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [7:0] payload_byte, [9:8] frame_status,
                                       // [17:10] payload_count, [23:18] zero
  logic        m_axis_tuser;           // [0] payload_valid
  logic        m_axis_tlast;           // frame_done
  logic        cfg_we_i    = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [7:0]  cfg_data_i  = 8'h00;

  nfc_response_frame_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Bytes still to be driven, and results the parser owes us, oldest first.
  rx_item_t    rx_bytes_q[$];
  res_t        frame_results_q[$];

  // Our own copy of the configuration registers and the parser context.
  logic [7:0]  cfg_command  = 8'h00;
  logic [7:0]  cfg_capacity = 8'hFF;
  phase_e      parse_phase  = PH_IDLE;
  logic [7:0]  bytes_left   = 8'h00;
  logic [7:0]  frame_len    = 8'h00;
  logic [7:0]  run_sum      = 8'h00;
  logic        overflow     = 1'b0;

  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned items_in_phase = 0;
  int unsigned idle_left      = 0;
  int unsigned stall_left     = 0;
  bit          hold_for_drain = 1'b0;
  bit          sender_gaps_on     = 1'b0;
  bit          receiver_stalls_on = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The run is bounded no matter what the design does with its handshakes.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    if (fail_count < MaxPrintedErr) begin
      $display("%0t: MISMATCH %s", $realtime, msg);
    end
    fail_count++;
  endtask

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    if (!enabled) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic void note_frame_end(input status_e status, input logic [7:0] count);
    res_t r;
    r = '{payload_valid: 1'b0, payload_byte: 8'h00, frame_done: 1'b1,
          frame_status: status, payload_count: count};
    frame_results_q.push_back(r);
    parse_phase = PH_IDLE;
  endfunction

  // Advances our copy of the parser by one accepted byte and records the
  // result, if any, that the byte must produce.
  function automatic void parse_rx_byte(input logic [7:0] b, input logic start);
    logic [7:0] code;
    res_t       r;
    code = cfg_command + 8'd1;
    if (start) begin
      // A frame start always restarts the parse, dropping any frame in flight.
      bytes_left = 8'h00;
      frame_len  = 8'h00;
      run_sum    = 8'h00;
      overflow   = 1'b0;
      if (b != FramePreamble) begin
        note_frame_end(ST_INVALID, 8'h00);
      end else begin
        parse_phase = PH_START1;
      end
      return;
    end
    case (parse_phase)
      PH_START1: begin
        if (b != FrameStart1) note_frame_end(ST_INVALID, 8'h00);
        else parse_phase = PH_START2;
      end
      PH_START2: begin
        if (b != FrameStart2) note_frame_end(ST_INVALID, 8'h00);
        else parse_phase = PH_LEN;
      end
      PH_LEN: begin
        frame_len   = b;
        parse_phase = PH_LCS;
      end
      PH_LCS: begin
        if (frame_len + b != 8'h00) begin
          note_frame_end(ST_INVALID, 8'h00);
        end else begin
          // Lengths below two wrap around to a large payload count.
          frame_len   = frame_len - 8'd2;
          parse_phase = PH_TFI;
        end
      end
      PH_TFI: begin
        if (b != FrameDirToHost) note_frame_end(ST_INVALID, 8'h00);
        else parse_phase = PH_CODE;
      end
      PH_CODE: begin
        if (b != code) begin
          note_frame_end(ST_INVALID, 8'h00);
        end else begin
          overflow    = frame_len > cfg_capacity;
          run_sum     = FrameDirToHost + code;
          bytes_left  = frame_len;
          parse_phase = (frame_len == 8'h00) ? PH_DCS : PH_DATA;
        end
      end
      PH_DATA: begin
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'h00) parse_phase = PH_DCS;
        // An oversized frame is drained without passing its payload out.
        if (!overflow) begin
          run_sum = run_sum + b;
          r = '{payload_valid: 1'b1, payload_byte: b, frame_done: 1'b0,
                frame_status: ST_OK, payload_count: 8'h00};
          frame_results_q.push_back(r);
        end
      end
      PH_DCS: begin
        if (!overflow && (run_sum + b != 8'h00)) note_frame_end(ST_INVALID, 8'h00);
        else parse_phase = PH_POST;
      end
      PH_POST: begin
        // The postamble value itself is never checked.
        note_frame_end(overflow ? ST_NOSPACE : ST_OK, frame_len);
      end
      default: begin
        // Bytes that arrive outside a frame are ignored.
        parse_phase = PH_IDLE;
      end
    endcase
  endfunction

  // Driver: presents queued bytes, holds a byte until it is taken, and
  // inserts random gaps. Now and then it holds off until the parser has
  // delivered everything it owes, so the output side drains mid-stream.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tuser  <= 1'b0;
      idle_left      = 0;
      hold_for_drain = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_rx_byte(s_axis_tdata, s_axis_tuser);
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // The transaction has not completed; keep the byte on the bus.
      end else if (idle_left > 0) begin
        idle_left--;
        s_axis_tvalid <= 1'b0;
      end else if (hold_for_drain && frame_results_q.size() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (rx_bytes_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_bytes_q[0].data;
        s_axis_tuser  <= rx_bytes_q[0].start;
        void'(rx_bytes_q.pop_front());
        hold_for_drain = ($urandom_range(0, 199) == 0);
        idle_left      = pick_gap(sender_gaps_on);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_result();
    res_t want;
    if (frame_results_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected result tuser=%b tlast=%b tdata=%h",
                              m_axis_tuser, m_axis_tlast, m_axis_tdata));
      return;
    end
    want = frame_results_q.pop_front();
    if (m_axis_tuser !== want.payload_valid) begin
      flag_mismatch($sformatf("payload_valid got %b want %b",
                              m_axis_tuser, want.payload_valid));
    end
    if (m_axis_tdata[7:0] !== want.payload_byte) begin
      flag_mismatch($sformatf("payload_byte got %h want %h",
                              m_axis_tdata[7:0], want.payload_byte));
    end
    if (m_axis_tlast !== want.frame_done) begin
      flag_mismatch($sformatf("frame_done got %b want %b",
                              m_axis_tlast, want.frame_done));
    end
    if (m_axis_tdata[9:8] !== want.frame_status) begin
      flag_mismatch($sformatf("frame_status got %0d want %0d",
                              m_axis_tdata[9:8], want.frame_status));
    end
    if (m_axis_tdata[17:10] !== want.payload_count) begin
      flag_mismatch($sformatf("payload_count got %0d want %0d",
                              m_axis_tdata[17:10], want.payload_count));
    end
  endtask

  // Monitor: checks every completed output transaction and stalls the
  // result channel at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left     = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left     = pick_gap(receiver_stalls_on);
      end
    end
  end

  task automatic push_rx(input logic [7:0] data, input logic start);
    rx_item_t it;
    it = '{data: data, start: start};
    rx_bytes_q.push_back(it);
    items_in_phase++;
  endtask

  // Payload content leans toward the all-zero and all-one bytes.
  function automatic logic [7:0] pick_payload_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Queues one frame with the given length byte, built for the command
  // currently configured, and damaged as the defect asks. A damaged header
  // ends the frame at the bad byte; a cut frame stops partway through.
  task automatic add_frame(input logic [7:0] len, input frame_defect_e defect);
    logic [7:0]  fb[$];
    logic [7:0]  code;
    logic [7:0]  sum;
    logic [7:0]  count;
    logic [7:0]  pb;
    int unsigned keep;
    int unsigned k;
    code  = cfg_command + 8'd1;
    count = len - 8'd2;
    sum   = FrameDirToHost + code;
    fb = '{FramePreamble, FrameStart1, FrameStart2, len, 8'd0 - len, FrameDirToHost, code};
    for (k = 0; k < count; k++) begin
      pb  = pick_payload_byte();
      sum = sum + pb;
      fb.push_back(pb);
    end
    fb.push_back(8'd0 - sum);
    fb.push_back(8'($urandom_range(0, 255)));
    keep = fb.size();
    case (defect)
      DEF_PREAMBLE: begin
        fb[0] = 8'($urandom_range(1, 255));
        keep  = 1;
      end
      DEF_START1: begin
        fb[1] = 8'($urandom_range(1, 255));
        keep  = 2;
      end
      DEF_START2: begin
        fb[2] = 8'($urandom_range(0, 254));
        keep  = 3;
      end
      DEF_LCS: begin
        fb[4] = fb[4] + 8'($urandom_range(1, 255));
        keep  = 5;
      end
      DEF_TFI: begin
        fb[5] = fb[5] ^ 8'($urandom_range(1, 255));
        keep  = 6;
      end
      DEF_CODE: begin
        fb[6] = fb[6] + 8'($urandom_range(1, 255));
        keep  = 7;
      end
      DEF_DCS: begin
        // Unless the frame overflows the capacity, the postamble that follows lands on an idle parser.
        fb[fb.size() - 2] = fb[fb.size() - 2] + 8'($urandom_range(1, 255));
      end
      DEF_CUT: begin
        keep = $urandom_range(1, fb.size() - 1);
      end
      default: begin
      end
    endcase
    for (k = 0; k < keep; k++) begin
      push_rx(fb[k], k == 0);
    end
  endtask

  // Mostly well-formed frames of small size, with some sized right at the
  // capacity boundary, plus damaged frames and stray bytes.
  task automatic add_random_frame();
    int unsigned   r;
    int unsigned   n;
    int unsigned   k;
    frame_defect_e defect;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      n = $urandom_range(0, 6);
    end else if (r < 85) begin
      n = $urandom_range(7, 20);
    end else if (cfg_capacity < 30) begin
      n = cfg_capacity + $urandom_range(0, 1);
    end else begin
      n = $urandom_range(21, 40);
    end
    r = $urandom_range(0, 99);
    if (r < 72) begin
      defect = DEF_NONE;
    end else if (r < 84) begin
      defect = frame_defect_e'($urandom_range(DEF_PREAMBLE, DEF_CODE));
    end else if (r < 90) begin
      defect = DEF_DCS;
    end else if (r < 96) begin
      defect = DEF_CUT;
    end else begin
      // Stray bytes on an idle link, sometimes with a bogus frame start.
      for (k = 0; k < $urandom_range(1, 3); k++) begin
        push_rx(8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 1) == 1) begin
        push_rx(8'($urandom_range(0, 255)), 1'b1);
      end
      return;
    end
    add_frame(8'(n + 2), defect);
    if (defect == DEF_NONE && $urandom_range(0, 9) == 0) begin
      push_rx(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic write_register(input logic index, input logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    if (index == CfgSentCommand) begin
      cfg_command = value;
    end else begin
      cfg_capacity = value;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits at falling edges, where every signal and queue has settled, until
  // all bytes have been taken and every owed result has arrived, then lets
  // the input and output registers empty out for bytes that produce no result.
  task automatic wait_until_quiet();
    do begin
      @(negedge clk_i);
    end while (rx_bytes_q.size() != 0 || s_axis_tvalid || frame_results_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0]  phase_cmd [NumPhases];
    logic [7:0]  phase_cap [NumPhases];
    int unsigned p;

    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames with the reset configuration (command 0, capacity 255).
    push_rx(8'hA5, 1'b0);        // stray byte while idle
    push_rx(8'hFF, 1'b1);        // frame start that is not a preamble
    add_frame(8'd2, DEF_NONE);   // empty payload, checksum right after the code
    add_frame(8'd5, DEF_CUT);    // abandoned by the next frame start
    add_frame(8'd3, DEF_NONE);
    add_frame(8'd3, DEF_DCS);
    add_frame(8'd4, DEF_NONE);
    wait_until_quiet();

    // Command 0xFF makes the expected code wrap to zero; capacity 0 drains
    // every frame that carries payload.
    phase_cmd = '{8'hFF, 8'h4A, 8'h12, 8'h80, 8'h00};
    phase_cap = '{8'h00, 8'h08, 8'hFF, 8'h03, 8'h00};
    phase_cmd[NumPhases - 1] = 8'($urandom_range(0, 255));
    phase_cap[NumPhases - 1] = 8'($urandom_range(0, 255));

    for (p = 0; p < NumPhases; p++) begin
      write_register(CfgSentCommand, phase_cmd[p]);
      write_register(CfgBufCapacity, phase_cap[p]);
      // One phase runs flat out on both sides.
      sender_gaps_on     = (p != 1 && p != 3);
      receiver_stalls_on = (p != 1 && p != 2);
      items_in_phase = 0;
      if (p == 2) begin
        add_frame(8'd1, DEF_NONE);   // length one: 255 payload bytes, all kept
      end
      if (p == 3) begin
        add_frame(8'd0, DEF_NONE);   // length zero: 254 payload bytes, drained
      end
      while (items_in_phase < PhaseItems) begin
        add_random_frame();
      end
      // Close on a complete frame so the parser is idle for the next write.
      add_frame(8'($urandom_range(2, 6)), DEF_NONE);
      wait_until_quiet();
    end

    if (frame_results_q.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", frame_results_q.size()));
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
